>>> rtl/core/fmpm_pkg.sv
package fmpm_pkg;

    localparam int unsigned IN_W  = 64;
    localparam int unsigned RES_W = 30;

    localparam logic [RES_W-1:0] FIB_PRIME = 30'd1000000007;

    // Barrett constant floor(2^60 / p), fits in 31 bits
    localparam logic [63:0] BARRETT_M64 = 64'h1000_0000_0000_0000 / 64'd1000000007;
    localparam logic [30:0] BARRETT_M   = BARRETT_M64[30:0];

    // cycles from issuing a product to reading it back from its holding register
    localparam int unsigned MUL_LAT = 5;

    typedef enum logic [1:0] {
        SEL_AA,
        SEL_BB,
        SEL_BT
    } t_sel;

    typedef struct packed {
        logic load;
        logic issue;
        t_sel sel;
        logic prep;
        logic combine;
        logic out_load;
    } t_dp_cmd;

    function automatic logic [RES_W-1:0] mod_add(
        input logic [RES_W-1:0] x,
        input logic [RES_W-1:0] y
    );
        logic [RES_W:0] s;
        logic [RES_W:0] d;
        s = {1'b0, x} + {1'b0, y};
        d = s - {1'b0, FIB_PRIME};
        if (s >= {1'b0, FIB_PRIME}) begin
            return d[RES_W-1:0];
        end
        return s[RES_W-1:0];
    endfunction

endpackage

>>> rtl/core/fmpm_modmul.sv
module fmpm_modmul (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  fmpm_pkg::t_sel               i_tag,
    input  logic [fmpm_pkg::RES_W-1:0]   i_a,
    input  logic [fmpm_pkg::RES_W-1:0]   i_b,
    output logic                         o_valid,
    output fmpm_pkg::t_sel               o_tag,
    output logic [fmpm_pkg::RES_W-1:0]   o_res
);

    localparam logic [31:0] P32  = 32'(fmpm_pkg::FIB_PRIME);
    localparam logic [31:0] P32X2 = 32'(2 * 64'(fmpm_pkg::FIB_PRIME));

    logic [59:0]          r_x;
    logic [61:0]          r_q2;
    logic [31:0]          r_xl1;
    logic [31:0]          r_xl2;
    logic [31:0]          r_qp;
    logic [2:0]           r_vld;
    fmpm_pkg::t_sel       r_tag [3];
    logic                 r_ovld;
    fmpm_pkg::t_sel       r_otag;
    logic [fmpm_pkg::RES_W-1:0] r_res;

    logic [31:0] diff;
    logic [31:0] diff_m1;
    logic [31:0] diff_m2;
    logic [31:0] n_red;

    // Barrett: remainder estimate is below 3p, so two corrections at most
    assign diff    = r_xl2 - r_qp;
    assign diff_m1 = diff - P32;
    assign diff_m2 = diff - P32X2;

    always_comb begin
        priority if (diff >= P32X2) begin
            n_red = diff_m2;
        end else if (diff >= P32) begin
            n_red = diff_m1;
        end else begin
            n_red = diff;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x    <= 60'(i_a) * 60'(i_b);
        r_q2   <= 62'(r_x[59:29]) * 62'(fmpm_pkg::BARRETT_M);
        r_xl1  <= r_x[31:0];
        r_qp   <= 32'(r_q2[61:31]) * P32;
        r_xl2  <= r_xl1;
        r_res  <= n_red[fmpm_pkg::RES_W-1:0];
        r_tag[0] <= i_tag;
        r_tag[1] <= r_tag[0];
        r_tag[2] <= r_tag[1];
        r_otag   <= r_tag[2];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_ovld <= 1'b0;
        end else begin
            r_vld  <= {r_vld[1:0], i_valid};
            r_ovld <= r_vld[2];
        end
    end

    assign o_valid = r_ovld;
    assign o_tag   = r_otag;
    assign o_res   = r_res;

endmodule

>>> rtl/core/fmpm_datapath.sv
module fmpm_datapath #(
    parameter int unsigned INDEX_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  fmpm_pkg::t_dp_cmd            i_cmd,
    input  logic [fmpm_pkg::IN_W-1:0]    i_index,
    output logic [fmpm_pkg::RES_W-1:0]   o_fib
);

    // running power kept as (a, b) = (F(k-1), F(k)); the matrix is symmetric
    logic [INDEX_BITS-1:0]       r_idx;
    logic [fmpm_pkg::RES_W-1:0]  r_a;
    logic [fmpm_pkg::RES_W-1:0]  r_b;
    logic [fmpm_pkg::RES_W-1:0]  r_t;
    logic [fmpm_pkg::RES_W-1:0]  r_paa;
    logic [fmpm_pkg::RES_W-1:0]  r_pbb;
    logic [fmpm_pkg::RES_W-1:0]  r_pbt;
    logic [fmpm_pkg::RES_W-1:0]  r_fib;

    logic [fmpm_pkg::RES_W-1:0]  op_a;
    logic [fmpm_pkg::RES_W-1:0]  op_b;
    logic                        mul_vld;
    fmpm_pkg::t_sel              mul_tag;
    logic [fmpm_pkg::RES_W-1:0]  mul_res;

    logic [fmpm_pkg::RES_W-1:0]  sq_a;
    logic [fmpm_pkg::RES_W-1:0]  sq_b;

    always_comb begin
        unique case (i_cmd.sel)
            fmpm_pkg::SEL_AA: begin
                op_a = r_a;
                op_b = r_a;
            end
            fmpm_pkg::SEL_BB: begin
                op_a = r_b;
                op_b = r_b;
            end
            fmpm_pkg::SEL_BT: begin
                op_a = r_b;
                op_b = r_t;
            end
            default: begin
                op_a = r_a;
                op_b = r_a;
            end
        endcase
    end

    fmpm_modmul u_modmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_cmd.issue),
        .i_tag   (i_cmd.sel),
        .i_a     (op_a),
        .i_b     (op_b),
        .o_valid (mul_vld),
        .o_tag   (mul_tag),
        .o_res   (mul_res)
    );

    // squaring: F(2k-1) = a^2 + b^2, F(2k) = b * (2a + b)
    assign sq_a = fmpm_pkg::mod_add(r_paa, r_pbb);
    assign sq_b = r_pbt;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_idx <= i_index[INDEX_BITS-1:0];
            r_a   <= fmpm_pkg::RES_W'(1);
            r_b   <= '0;
        end else if (i_cmd.combine) begin
            r_idx <= {r_idx[INDEX_BITS-2:0], 1'b0};
            if (r_idx[INDEX_BITS-1]) begin
                r_a <= sq_b;
                r_b <= fmpm_pkg::mod_add(sq_a, sq_b);
            end else begin
                r_a <= sq_a;
                r_b <= sq_b;
            end
        end

        if (i_cmd.prep) begin
            r_t <= fmpm_pkg::mod_add(fmpm_pkg::mod_add(r_a, r_a), r_b);
        end

        if (mul_vld) begin
            unique case (mul_tag)
                fmpm_pkg::SEL_AA: r_paa <= mul_res;
                fmpm_pkg::SEL_BB: r_pbb <= mul_res;
                fmpm_pkg::SEL_BT: r_pbt <= mul_res;
                default:          r_pbt <= mul_res;
            endcase
        end

        if (i_cmd.out_load) begin
            r_fib <= r_b;
        end
    end

    assign o_fib = r_fib;

endmodule

>>> rtl/core/fmpm_ctrl.sv
module fmpm_ctrl #(
    parameter int unsigned INDEX_BITS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_out_ready,
    output logic              o_out_valid,
    output fmpm_pkg::t_dp_cmd o_cmd
);

    localparam int unsigned BIT_W  = $clog2(INDEX_BITS);
    localparam int unsigned WAIT_W = $clog2(fmpm_pkg::MUL_LAT);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ_AA,
        S_SQ_BB,
        S_SQ_BT,
        S_WAIT,
        S_COMBINE,
        S_DONE
    } t_state;

    t_state            r_state;
    logic [BIT_W-1:0]  r_bit;
    logic [WAIT_W-1:0] r_wait;
    logic              r_out_valid;
    logic              out_free;

    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_cmd          = '0;
        o_cmd.sel      = fmpm_pkg::SEL_AA;
        unique case (r_state)
            S_IDLE:    o_cmd.load = i_in_valid;
            S_SQ_AA: begin
                o_cmd.issue = 1'b1;
                o_cmd.sel   = fmpm_pkg::SEL_AA;
                o_cmd.prep  = 1'b1;
            end
            S_SQ_BB: begin
                o_cmd.issue = 1'b1;
                o_cmd.sel   = fmpm_pkg::SEL_BB;
            end
            S_SQ_BT: begin
                o_cmd.issue = 1'b1;
                o_cmd.sel   = fmpm_pkg::SEL_BT;
            end
            S_WAIT:    o_cmd.issue = 1'b0;
            S_COMBINE: o_cmd.combine = 1'b1;
            S_DONE:    o_cmd.out_load = out_free;
            default:   o_cmd.issue = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= '0;
            r_wait      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_DONE && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_bit   <= BIT_W'(INDEX_BITS - 1);
                        r_state <= S_SQ_AA;
                    end
                end
                S_SQ_AA: r_state <= S_SQ_BB;
                S_SQ_BB: r_state <= S_SQ_BT;
                S_SQ_BT: begin
                    r_wait  <= WAIT_W'(fmpm_pkg::MUL_LAT - 2);
                    r_state <= S_WAIT;
                end
                S_WAIT: begin
                    if (r_wait == '0) begin
                        r_state <= S_COMBINE;
                    end else begin
                        r_wait <= r_wait - WAIT_W'(1);
                    end
                end
                S_COMBINE: begin
                    if (r_bit == '0) begin
                        r_state <= S_DONE;
                    end else begin
                        r_bit   <= r_bit - BIT_W'(1);
                        r_state <= S_SQ_AA;
                    end
                end
                S_DONE: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

>>> rtl/core/fibonacci_mod_prime_matrix_power.sv
// channel  | handshake                    | beat payload
// ---------+------------------------------+-------------------------------
// in       | i_in_valid / o_in_ready      | i_index_n   [63:0] index n
// out      | o_out_valid / i_out_ready    | o_fib_value [29:0] F(n) mod p
//
// Each index bit takes three products through the shared four-stage Barrett
// multiplier, a wait for the last one to land, then a combine.
// Synchronous active-low reset clears the controller and multiplier valids.
// A finished result sits in the output register; the next item is taken
// while it waits, and a stalled output holds the block in its final state.
module fibonacci_mod_prime_matrix_power #(
    parameter int unsigned INDEX_BITS = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [fmpm_pkg::IN_W-1:0]    i_index_n,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [fmpm_pkg::RES_W-1:0]   o_fib_value
);

    fmpm_pkg::t_dp_cmd cmd;

    fmpm_ctrl #(
        .INDEX_BITS (INDEX_BITS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    fmpm_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_index (i_index_n),
        .o_fib   (o_fib_value)
    );

endmodule
